// ===== src/bfa_pkg.sv =====
// Shared command and status codes for the bitmap frame allocator.
`default_nettype none

package bfa_pkg;

  localparam logic [2:0] KIND_USABLE   = 3'd0;
  localparam logic [2:0] KIND_RESERVE  = 3'd1;
  localparam logic [2:0] KIND_ALLOC    = 3'd2;
  localparam logic [2:0] KIND_ALLOC_AT = 3'd3;
  localparam logic [2:0] KIND_FREE     = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_FREE    = 3'd1;
  localparam logic [2:0] ST_DOUBLE     = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOC  = 3'd3;
  localparam logic [2:0] ST_RANGE      = 3'd4;

endpackage

`default_nettype wire

// ===== src/bfa_map_ram.sv =====
// Simple dual-port bitmap memory with a registered read port.
`default_nettype none

module bfa_map_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/bfa_div.sv =====
// Frame index split into bitmap word and bit by shift and mask, with registered outputs.
`default_nettype none

module bfa_div #(
  parameter int DVD_W   = 15,
  parameter int DIVISOR = 32,
  localparam int RM_W   = $clog2(DIVISOR)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  output logic                  done,
  output logic      [DVD_W-1:0] quot,
  output logic      [RM_W-1:0]  rem
);

  logic [DVD_W-1:0] quot_r, quot_nxt;
  logic [RM_W-1:0]  rem_r, rem_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    done_nxt = start;
    if (start) begin
      quot_nxt = dividend >> RM_W;
      rem_nxt  = dividend[RM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== src/bitmap_frame_allocator.sv =====
// Bitmap physical frame allocator: command sequencer around the bitmap memory.
//
// Requests enter on the in_ stream: in_tuser carries the command kind, in_tdata
// the byte address and the region length. Each request returns exactly one
// result on the out_ stream: out_tdata is the allocated frame address (zero
// unless an allocation succeeded), out_tuser the status code.
// Both bitmaps share one memory word per bitmap word (allocated over usable),
// read through a registered port and written back after the update.
// Steps per request, from accept until the finish step raises the result:
//   allocate first free: decode, then a scan of bitmap words to a free frame or the limit
//   region commands: decode, index split, then a walk over the words touched
//   allocate at address and free: decode, index split, then one bit update
//   out-of-range and empty requests: decode only
// FRAME_BYTES and WORD_BITS are powers of two; frame splits are shifts and masks.
// One request is in work at a time; the next is accepted once the result is
// raised, so the scan loop and the region walk set the throughput.
// After reset the memory is cleared at one word per cycle, all MAP_WORDS words,
// while in_tready stays low. A stalled result waits in the output register; the
// sequencer holds the next result until that register is taken.
`default_nettype none

module bitmap_frame_allocator #(
  parameter int FRAME_BYTES = 4096,
  parameter int MAP_WORDS   = 1024,
  parameter int WORD_BITS   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] address, [63:32] length
  input  wire logic [2:0]  in_tuser,   // [2:0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] grant_addr
  output logic      [2:0]  out_tuser   // [2:0] status
);

  import bfa_pkg::*;

  localparam int     FS         = $clog2(FRAME_BYTES);
  localparam longint CAP_L      = longint'(MAP_WORDS) * longint'(WORD_BITS);
  localparam longint ADDR_FR_L  = longint'(1) << (32 - FS);
  localparam longint LIMIT_L    = (CAP_L < ADDR_FR_L) ? CAP_L : ADDR_FR_L;
  localparam int     IDX_W      = $clog2(CAP_L);
  localparam int     FW         = ((34 - FS) > (IDX_W + 1)) ? (34 - FS) : (IDX_W + 1);
  localparam int     WA         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int     BI_W       = $clog2(WORD_BITS);
  localparam int     HW         = $clog2(WORD_BITS + 1);
  localparam int     DW         = 2 * WORD_BITS;
  localparam logic [FW-1:0] CAP_F   = FW'(CAP_L);
  localparam logic [FW-1:0] LIMIT_F = FW'(LIMIT_L);
  localparam logic [FW-1:0] WB_F    = FW'(WORD_BITS);
  localparam logic [31:0]   OFF_MASK = 32'(FRAME_BYTES - 1);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_REGION = 8'b0001_0000,
    S_POINT  = 8'b0010_0000,
    S_ALLOC  = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [WA-1:0]     clr_r, clr_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [FW-1:0]     first_r, first_nxt;
  logic [FW-1:0]     end_r, end_nxt;
  logic [FW-1:0]     base_r, base_nxt;
  logic [WA-1:0]     w_r, w_nxt;
  logic [HW-1:0]     lo_r, lo_nxt;
  logic [BI_W-1:0]   bit_r, bit_nxt;
  logic [31:0]       res_fa_r, res_fa_nxt;
  logic [2:0]        res_st_r, res_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_fa_r, out_fa_nxt;
  logic [2:0]        out_st_r, out_st_nxt;

  logic              mem_we, mem_re;
  logic [WA-1:0]     mem_waddr, mem_raddr;
  logic [DW-1:0]     mem_wdata, mem_rdata;
  logic              div_start, div_done;
  logic [IDX_W-1:0]  div_dvd, div_quot;
  logic [BI_W-1:0]   div_rem;

  logic [32:0]          addr_up, len_up;
  logic [FW-1:0]        first_up, first_dn, cnt_up, cnt_dn;
  logic [FW-1:0]        first_sel, cnt_sel, end_raw, end_cl;
  logic [FW-1:0]        next_base, span;
  logic [HW-1:0]        hi;
  logic [WORD_BITS-1:0] usable_w, alloc_w, mask, cand, cand_oh, bit_oh;
  logic [BI_W-1:0]      low_idx;
  logic [FW-1:0]        found_fr;
  logic [63:0]          found_fa;
  logic                 alloc_hit;

  bfa_map_ram #(
    .DEPTH  (MAP_WORDS),
    .DATA_W (DW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bfa_div #(
    .DVD_W   (IDX_W),
    .DIVISOR (WORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // region bounds, word masks and free-frame search
  always_comb begin
    addr_up   = {1'b0, addr_r} + 33'(FRAME_BYTES - 1);
    len_up    = {1'b0, len_r} + 33'(FRAME_BYTES - 1);
    first_up  = FW'(addr_up >> FS);
    first_dn  = FW'(addr_r >> FS);
    cnt_dn    = FW'(len_r >> FS);
    cnt_up    = FW'(len_up >> FS);
    first_sel = (kind_r == KIND_USABLE) ? first_up : first_dn;
    cnt_sel   = (kind_r == KIND_USABLE) ? cnt_dn : cnt_up;
    end_raw   = first_sel + cnt_sel;
    end_cl    = (end_raw > CAP_F) ? CAP_F : end_raw;

    next_base = base_r + WB_F;
    span      = state_r == S_ALLOC ? (LIMIT_F - base_r) : (end_r - base_r);
    hi        = (span >= WB_F) ? HW'(WORD_BITS) : span[HW-1:0];
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = (HW'(j) >= lo_r) && (HW'(j) < hi);
    end

    usable_w = mem_rdata[WORD_BITS-1:0];
    alloc_w  = mem_rdata[DW-1:WORD_BITS];
    cand     = usable_w & ~alloc_w & mask;
    cand_oh  = cand & (~cand + WORD_BITS'(1));
    low_idx  = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (cand_oh[j]) begin
        low_idx = low_idx | BI_W'(j);
      end
    end
    found_fr  = base_r + FW'(low_idx);
    found_fa  = 64'(found_fr) << FS;
    bit_oh    = WORD_BITS'(1) << bit_r;
    alloc_hit = alloc_w[bit_r];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    len_nxt       = len_r;
    first_nxt     = first_r;
    end_nxt       = end_r;
    base_nxt      = base_r;
    w_nxt         = w_r;
    lo_nxt        = lo_r;
    bit_nxt       = bit_r;
    res_fa_nxt    = res_fa_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_fa_nxt    = out_fa_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_waddr     = w_r;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = w_r;
    div_start     = 1'b0;
    div_dvd       = first_dn[IDX_W-1:0];
    in_tready     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + WA'(1);
        if (clr_r == WA'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          addr_nxt  = in_tdata[31:0];
          len_nxt   = in_tdata[63:32];
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        first_nxt  = first_sel;
        end_nxt    = end_cl;
        res_fa_nxt = '0;
        res_st_nxt = ST_OK;
        priority if (kind_r == KIND_USABLE || kind_r == KIND_RESERVE) begin
          if (first_sel >= end_cl) begin
            state_nxt = S_FIN;
          end else begin
            div_start = 1'b1;
            div_dvd   = first_sel[IDX_W-1:0];
            state_nxt = S_DIV;
          end
        end else if (kind_r == KIND_ALLOC) begin
          w_nxt     = '0;
          base_nxt  = '0;
          lo_nxt    = '0;
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = S_ALLOC;
        end else if (kind_r == KIND_ALLOC_AT || kind_r == KIND_FREE) begin
          if (first_dn >= CAP_F) begin
            res_st_nxt = ST_RANGE;
            state_nxt  = S_FIN;
          end else begin
            div_start = 1'b1;
            div_dvd   = first_dn[IDX_W-1:0];
            state_nxt = S_DIV;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (div_done) begin
          w_nxt     = div_quot[WA-1:0];
          bit_nxt   = div_rem;
          lo_nxt    = HW'(div_rem);
          base_nxt  = first_r - FW'(div_rem);
          mem_re    = 1'b1;
          mem_raddr = div_quot[WA-1:0];
          state_nxt = (kind_r == KIND_USABLE || kind_r == KIND_RESERVE) ? S_REGION
                                                                         : S_POINT;
        end
      end
      S_REGION: begin
        mem_we    = 1'b1;
        mem_waddr = w_r;
        mem_wdata = {alloc_w, (kind_r == KIND_USABLE) ? (usable_w | mask)
                                                       : (usable_w & ~mask)};
        if (next_base < end_r) begin
          w_nxt     = w_r + WA'(1);
          base_nxt  = next_base;
          lo_nxt    = '0;
          mem_re    = 1'b1;
          mem_raddr = w_r + WA'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_POINT: begin
        state_nxt = S_FIN;
        if (kind_r == KIND_ALLOC_AT) begin
          if (alloc_hit) begin
            res_st_nxt = ST_DOUBLE;
          end else begin
            mem_we     = 1'b1;
            mem_wdata  = {alloc_w | bit_oh, usable_w};
            res_fa_nxt = addr_r & ~OFF_MASK;
          end
        end else begin
          if (!alloc_hit) begin
            res_st_nxt = ST_NOT_ALLOC;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {alloc_w & ~bit_oh, usable_w};
          end
        end
      end
      S_ALLOC: begin
        if (cand != '0) begin
          mem_we     = 1'b1;
          mem_wdata  = {alloc_w | cand_oh, usable_w};
          res_fa_nxt = found_fa[31:0];
          state_nxt  = S_FIN;
        end else if (next_base >= LIMIT_F) begin
          res_st_nxt = ST_NO_FREE;
          state_nxt  = S_FIN;
        end else begin
          w_nxt     = w_r + WA'(1);
          base_nxt  = next_base;
          mem_re    = 1'b1;
          mem_raddr = w_r + WA'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_fa_nxt    = res_fa_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    addr_r   <= addr_nxt;
    len_r    <= len_nxt;
    first_r  <= first_nxt;
    end_r    <= end_nxt;
    base_r   <= base_nxt;
    w_r      <= w_nxt;
    lo_r     <= lo_nxt;
    bit_r    <= bit_nxt;
    res_fa_r <= res_fa_nxt;
    res_st_r <= res_st_nxt;
    out_fa_r <= out_fa_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_fa_r;
  assign out_tuser  = out_st_r;

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_tready)
    else $error("request accepted during memory clear");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish step");

  a_no_rw_same_word: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write of the same bitmap word in one cycle");

  a_frame_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_fa_r[FS-1:0] == '0)
    else $error("frame address not aligned to a frame");

  a_error_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r != ST_OK |-> out_fa_r == '0)
    else $error("error result carries a frame address");

endmodule

`default_nettype wire
